FILE: src/lexicographic_permutation_step_defines.svh
// Assertion macros used by the permutation step RTL.
`ifndef LEXICOGRAPHIC_PERMUTATION_STEP_DEFINES_SVH
`define LEXICOGRAPHIC_PERMUTATION_STEP_DEFINES_SVH

// Same-cycle implication.
`define LPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lps_pkg.sv
// Shared constants, types and helpers of the permutation step block.
`default_nettype none

package lps_pkg;

    localparam int MAX_LEN  = 16;
    localparam int ELEM_W   = 16;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_ADV  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ELEM_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic                valid;
        logic [ELEM_W-1:0]   element;
        logic                last;
        logic [STATUS_W-1:0] status;
    } t_emit;

    // x comes strictly before y in the selected order
    function automatic logic precedes(logic [ELEM_W-1:0] x, logic [ELEM_W-1:0] y,
                                      logic back);
        return back ? (x > y) : (x < y);
    endfunction

endpackage

`default_nettype wire

FILE: src/lps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/lps_ctrl.sv
// Load, pivot search, swap, tail reversal and emit sequencer around the store.
`default_nettype none
`include "lexicographic_permutation_step_defines.svh"

module lps_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_wdata,
    input  wire logic                        i_in_valid,
    input  wire logic [lps_pkg::ELEM_W-1:0]  i_element,
    input  wire logic                        i_last_in,
    output logic                             o_in_ready,
    output lps_pkg::t_ram_req                o_ram,
    input  wire logic [lps_pkg::ELEM_W-1:0]  i_rdata,
    output lps_pkg::t_emit                   o_emit,
    input  wire logic                        i_emit_take
);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_PFIRST = 4'd2;
    localparam logic [3:0] S_PCMP   = 4'd3;
    localparam logic [3:0] S_JCMP   = 4'd4;
    localparam logic [3:0] S_SWAP   = 4'd5;
    localparam logic [3:0] S_RA     = 4'd6;
    localparam logic [3:0] S_RB     = 4'd7;
    localparam logic [3:0] S_RWA    = 4'd8;
    localparam logic [3:0] S_RWB    = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;

    localparam int AW = lps_pkg::ADDR_W;
    localparam int CW = lps_pkg::CNT_W;
    localparam int EW = lps_pkg::ELEM_W;

    logic [3:0]                  r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_ovf, n_ovf;
    logic                        r_dir;
    logic [AW-1:0]               r_k, n_k;
    logic [AW-1:0]               r_i, n_i;
    logic [AW-1:0]               r_j, n_j;
    logic [AW-1:0]               r_a, n_a;
    logic [AW-1:0]               r_b, n_b;
    logic [EW-1:0]               r_pv, n_pv;
    logic [EW-1:0]               r_prev, n_prev;
    logic [EW-1:0]               r_tmp, n_tmp;
    logic [lps_pkg::STATUS_W-1:0] r_st, n_st;

    logic [AW-1:0] nm1;
    logic          accept;
    logic          emit_last;

    // last stored position, valid once at least one element is held
    assign nm1       = AW'(r_count - CW'(1));
    assign accept    = i_in_valid && (r_state == S_LOAD);
    assign emit_last = ({1'b0, r_k} == (r_count - CW'(1)));

    assign o_in_ready     = (r_state == S_LOAD);
    assign o_emit.valid   = (r_state == S_EMIT);
    assign o_emit.element = i_rdata;
    assign o_emit.last    = emit_last;
    assign o_emit.status  = r_st;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        n_a     = r_a;
        n_b     = r_b;
        n_pv    = r_pv;
        n_prev  = r_prev;
        n_tmp   = r_tmp;
        n_st    = r_st;
        o_ram   = '0;

        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (r_count < CW'(lps_pkg::MAX_LEN)) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_count[AW-1:0];
                        o_ram.wdata = i_element;
                        n_count     = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_in) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                // settle state so the closing element's write has landed
                priority if (r_ovf) begin
                    n_st        = lps_pkg::ST_OVF;
                    n_k         = '0;
                    o_ram.re    = 1'b1;
                    o_ram.raddr = '0;
                    n_state     = S_EMIT;
                end else if (r_count < CW'(2)) begin
                    n_st        = lps_pkg::ST_NONE;
                    n_k         = '0;
                    o_ram.re    = 1'b1;
                    o_ram.raddr = '0;
                    n_state     = S_EMIT;
                end else begin
                    n_k         = nm1;
                    o_ram.re    = 1'b1;
                    o_ram.raddr = nm1;
                    n_state     = S_PFIRST;
                end
            end
            S_PFIRST: begin
                n_prev      = i_rdata;
                n_k         = r_k - AW'(1);
                o_ram.re    = 1'b1;
                o_ram.raddr = r_k - AW'(1);
                n_state     = S_PCMP;
            end
            S_PCMP: begin
                // i_rdata holds s[k], r_prev holds s[k+1]
                priority if (lps_pkg::precedes(i_rdata, r_prev, r_dir)) begin
                    n_i         = r_k;
                    n_pv        = i_rdata;
                    n_j         = nm1;
                    o_ram.re    = 1'b1;
                    o_ram.raddr = nm1;
                    n_state     = S_JCMP;
                end else if (r_k == '0) begin
                    n_st        = lps_pkg::ST_NONE;
                    o_ram.re    = 1'b1;
                    o_ram.raddr = '0;
                    n_state     = S_EMIT;
                end else begin
                    n_prev      = i_rdata;
                    n_k         = r_k - AW'(1);
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_k - AW'(1);
                end
            end
            S_JCMP: begin
                // rightmost element after the pivot in the chosen order; stops above i
                if (lps_pkg::precedes(r_pv, i_rdata, r_dir)) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_i;
                    o_ram.wdata = i_rdata;
                    n_state     = S_SWAP;
                end else begin
                    n_j         = r_j - AW'(1);
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_j - AW'(1);
                end
            end
            S_SWAP: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_j;
                o_ram.wdata = r_pv;
                n_a         = r_i + AW'(1);
                n_b         = nm1;
                n_st        = lps_pkg::ST_ADV;
                if ((r_i + AW'(1)) < nm1) begin
                    n_state = S_RA;
                end else begin
                    // j is at least one, so the read of entry zero never meets the write
                    n_k         = '0;
                    o_ram.re    = 1'b1;
                    o_ram.raddr = '0;
                    n_state     = S_EMIT;
                end
            end
            S_RA: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = r_a;
                n_state     = S_RB;
            end
            S_RB: begin
                n_tmp       = i_rdata;
                o_ram.re    = 1'b1;
                o_ram.raddr = r_b;
                n_state     = S_RWA;
            end
            S_RWA: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_a;
                o_ram.wdata = i_rdata;
                n_state     = S_RWB;
            end
            S_RWB: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_b;
                o_ram.wdata = r_tmp;
                n_a         = r_a + AW'(1);
                n_b         = r_b - AW'(1);
                if ((r_a + AW'(1)) < (r_b - AW'(1))) begin
                    n_state = S_RA;
                end else begin
                    n_k         = '0;
                    o_ram.re    = 1'b1;
                    o_ram.raddr = '0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_emit_take) begin
                    if (emit_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k         = r_k + AW'(1);
                        o_ram.re    = 1'b1;
                        o_ram.raddr = r_k + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_dir   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (i_cfg_we) begin
                r_dir <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_i    <= n_i;
        r_j    <= n_j;
        r_a    <= n_a;
        r_b    <= n_b;
        r_pv   <= n_pv;
        r_prev <= n_prev;
        r_tmp  <= n_tmp;
        r_st   <= n_st;
    end

    `LPS_ASSERT_IMP(a_no_rw_collide, i_clk, i_rst_n, o_ram.we && o_ram.re,
        o_ram.waddr != o_ram.raddr, "store read and write hit the same entry")
    `LPS_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1,
        r_count <= CW'(lps_pkg::MAX_LEN), "load count above capacity")
    `LPS_ASSERT_IMP(a_emit_in_range, i_clk, i_rst_n, o_emit.valid,
        {1'b0, r_k} < r_count, "emit index beyond sequence length")
    `LPS_ASSERT_IMP(a_jscan_above_pivot, i_clk, i_rst_n, r_state == S_JCMP,
        r_j > r_i, "swap search fell to the pivot")
    `LPS_ASSERT_NXT(a_close_clears, i_clk, i_rst_n, o_emit.valid && i_emit_take && emit_last,
        (r_state == S_LOAD) && (r_count == '0) && !r_ovf, "closing did not clear load state")

endmodule

`default_nettype wire

FILE: src/lexicographic_permutation_step.sv
// Top level: sequence store, sequencer and registered result stage.
//
// Elements load at one per cycle (input not stalled) into a 16-entry store with a
// single write and a single registered read port. The transaction marked last closes
// the sequence; the input is then stalled while the sequencer works through the
// store: a settle state, a scan from the right for the pivot, a scan for the swap
// partner, a state to finish the swap, read and write states per element pair of the
// tail reversal, then one result per cycle while the output is not stalled.
// A sequence that overflowed, is shorter than two, or has no successor is emitted
// unchanged with the matching status. Loading resumes as soon as the last result
// enters the output register.
`default_nettype none

module lexicographic_permutation_step (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic                                 i_cfg_wdata,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [lps_pkg::ELEM_W-1:0]           i_element,
    input  wire logic                                 i_last_in,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic      [lps_pkg::ELEM_W-1:0]           o_element_out,
    output logic                                      o_last_out,
    output logic      [lps_pkg::STATUS_W-1:0]         o_status
);

    lps_pkg::t_ram_req              ram_req;
    lps_pkg::t_emit                 emit;
    logic [lps_pkg::ELEM_W-1:0]     rdata;
    logic                           in_ready;
    logic                           take;

    logic                           r_o_valid;
    logic [lps_pkg::ELEM_W-1:0]     r_o_element;
    logic                           r_o_last;
    logic [lps_pkg::STATUS_W-1:0]   r_o_status;

    assign take    = emit.valid && (!r_o_valid || !i_stall);
    assign o_stall = !in_ready;

    lps_ram #(
        .WIDTH (lps_pkg::ELEM_W),
        .DEPTH (lps_pkg::MAX_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    lps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_valid),
        .i_element   (i_element),
        .i_last_in   (i_last_in),
        .o_in_ready  (in_ready),
        .o_ram       (ram_req),
        .i_rdata     (rdata),
        .o_emit      (emit),
        .i_emit_take (take)
    );

    // result register: refills in the cycle the held transaction leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (take) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_element <= emit.element;
            r_o_last    <= emit.last;
            r_o_status  <= emit.status;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_element_out = r_o_element;
    assign o_last_out    = r_o_last;
    assign o_status      = r_o_status;

endmodule

`default_nettype wire

FILE: dv/lexicographic_permutation_step_tb.sv
// Self-checking testbench for the lexicographic permutation step block.
`timescale 1ns / 100ps

module lexicographic_permutation_step_tb;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 180;
    localparam int PHASE_ITEMS   = 45;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES   = 100;
    localparam int N_DIRECTED    = 26;

    typedef struct packed {
        logic                         dir;
        logic [lps_pkg::ELEM_W-1:0]   elem;
        logic                         last;
        logic                         typed;
        logic [lps_pkg::STATUS_W-1:0] status;
    } t_stim_row;

    typedef struct packed {
        logic [lps_pkg::ELEM_W-1:0]   elem;
        logic                         last;
        logic [lps_pkg::STATUS_W-1:0] status;
    } t_perm_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic                         i_cfg_wdata = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [lps_pkg::ELEM_W-1:0]   i_element = '0;
    logic                         i_last_in = 1'b0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic [lps_pkg::ELEM_W-1:0]   o_element_out;
    logic                         o_last_out;
    logic [lps_pkg::STATUS_W-1:0] o_status;

    // predictor state
    logic [lps_pkg::ELEM_W-1:0] arrangement [lps_pkg::MAX_LEN];
    int unsigned                held_count = 0;
    bit                         dropped_any = 1'b0;
    logic                       step_back = 1'b0;
    t_perm_result               pending_results [$];

    int  fail_count = 0;
    int  rand_sent = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;

    t_stim_row directed_rows [N_DIRECTED];

    lexicographic_permutation_step u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_element     (i_element),
        .i_last_in     (i_last_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_element_out (o_element_out),
        .o_last_out    (o_last_out),
        .o_status      (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit ranks_lower(logic [lps_pkg::ELEM_W-1:0] x,
                                       logic [lps_pkg::ELEM_W-1:0] y, logic back);
        return back ? (x > y) : (x < y);
    endfunction

    // In-place step of the held arrangement; 0 when no neighbor exists.
    function automatic bit step_arrangement(int n, logic back);
        int                         p;
        int                         j;
        int                         a;
        int                         b;
        logic [lps_pkg::ELEM_W-1:0] t;
        if (n < 2) return 1'b0;
        p = n - 2;
        while (p >= 0 && !ranks_lower(arrangement[p], arrangement[p+1], back)) p--;
        if (p < 0) return 1'b0;
        j = n - 1;
        while (!ranks_lower(arrangement[p], arrangement[j], back)) j--;
        t = arrangement[p];
        arrangement[p] = arrangement[j];
        arrangement[j] = t;
        a = p + 1;
        b = n - 1;
        while (a < b) begin
            t = arrangement[a];
            arrangement[a] = arrangement[b];
            arrangement[b] = t;
            a++;
            b--;
        end
        return 1'b1;
    endfunction

    function automatic void absorb_element(logic [lps_pkg::ELEM_W-1:0] e, logic l,
                                           logic use_typed,
                                           logic [lps_pkg::STATUS_W-1:0] typed);
        logic [lps_pkg::STATUS_W-1:0] st;
        t_perm_result                 r;
        if (held_count < lps_pkg::MAX_LEN) begin
            arrangement[held_count] = e;
            held_count++;
        end else begin
            dropped_any = 1'b1;
        end
        if (!l) return;
        if (dropped_any) st = lps_pkg::ST_OVF;
        else if (step_arrangement(held_count, step_back)) st = lps_pkg::ST_ADV;
        else st = lps_pkg::ST_NONE;
        if (use_typed) st = typed;
        for (int k = 0; k < held_count; k++) begin
            r.elem   = arrangement[k];
            r.last   = (k == held_count - 1);
            r.status = st;
            pending_results.push_back(r);
        end
        held_count  = 0;
        dropped_any = 1'b0;
    endfunction

    task automatic push_element(input logic [lps_pkg::ELEM_W-1:0] e, input logic l,
                                input logic use_typed,
                                input logic [lps_pkg::STATUS_W-1:0] typed);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_element = e;
        i_last_in = l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        absorb_element(e, l, use_typed, typed);
    endtask

    // Sender holds off until every expected result is back.
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_direction(input logic d);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = d;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        step_back   = d;
    endtask

    task automatic send_random_sequence();
        logic [lps_pkg::ELEM_W-1:0] vals [$];
        int                         len_pick;
        int                         len;
        int                         mode;
        len_pick = $urandom_range(0, 19);
        if (len_pick < 12) len = $urandom_range(1, 5);
        else if (len_pick < 18) len = $urandom_range(6, lps_pkg::MAX_LEN);
        else len = $urandom_range(lps_pkg::MAX_LEN + 1, lps_pkg::MAX_LEN + 4);
        mode = $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
            case (mode)
                0: vals.push_back(lps_pkg::ELEM_W'($urandom));
                1: vals.push_back(lps_pkg::ELEM_W'($urandom_range(0, 3)));
                2: vals.push_back(lps_pkg::ELEM_W'($urandom_range(0, 7)));
                default: vals.push_back($urandom_range(0, 1) ?
                                        {lps_pkg::ELEM_W{1'b1}} : {lps_pkg::ELEM_W{1'b0}});
            endcase
        end
        // sorted runs hit the no-neighbor case in one direction or the other
        if (mode == 2) begin
            if ($urandom_range(0, 1)) vals.sort();
            else vals.rsort();
        end
        for (int k = 0; k < len; k++) begin
            push_element(vals[k], k == len - 1, 1'b0, lps_pkg::ST_ADV);
        end
        rand_sent += len;
    endtask

    // receive side: random stall ahead of each transaction while rx_idle is set
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = rx_idle ? $urandom_range(0, 16) : 0;
            @(negedge i_clk);
            if (gap > 0) begin
                i_stall = 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall = 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_perm_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: element_out %h last_out %b status %0d",
                       o_element_out, o_last_out, o_status);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_element_out !== want.elem) begin
                    $error("element_out: expected %h, got %h", want.elem, o_element_out);
                    fail_count++;
                end
                if (o_last_out !== want.last) begin
                    $error("last_out: expected %b, got %b", want.last, o_last_out);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[lexicographic_permutation_step] ERROR");
        $finish;
    end

    initial begin
        int phase;
        directed_rows = '{
            '{1'b0, 16'hFFFF, 1'b1, 1'b1, lps_pkg::ST_NONE},  // single element
            '{1'b0, 16'h0000, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'hFFFF, 1'b1, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'hFFFF, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'h0000, 1'b1, 1'b1, lps_pkg::ST_NONE},  // descending, no successor
            '{1'b0, 16'h0000, 1'b0, 1'b0, lps_pkg::ST_ADV},   // overflow run starts
            '{1'b0, 16'hFFFF, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'h8000, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'h0001, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'hAAAA, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'h5555, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'h1234, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'h0F0F, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'hF0F0, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'h00FF, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'hFF00, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'h7FFF, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'hFFFE, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'h3C3C, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'hC3C3, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'h0002, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b0, 16'hBEEF, 1'b1, 1'b1, lps_pkg::ST_OVF},   // dropped, closes the run
            '{1'b1, 16'h0003, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b1, 16'h0003, 1'b1, 1'b1, lps_pkg::ST_NONE},  // duplicates, already first
            '{1'b1, 16'h0002, 1'b0, 1'b0, lps_pkg::ST_ADV},
            '{1'b1, 16'h0001, 1'b1, 1'b0, lps_pkg::ST_ADV}
        };

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_direction(1'b0);

        for (int r = 0; r < N_DIRECTED; r++) begin
            if (held_count == 0 && directed_rows[r].dir != step_back) begin
                wait_for_drain();
                write_direction(directed_rows[r].dir);
            end
            push_element(directed_rows[r].elem, directed_rows[r].last,
                         directed_rows[r].typed, directed_rows[r].status);
        end

        phase = 0;
        while (rand_sent < RANDOM_ITEMS) begin
            wait_for_drain();
            write_direction(phase[0] ? 1'b0 : 1'b1);
            tx_idle = (phase % 4 == 0) || (phase % 4 == 2);
            rx_idle = (phase % 4 == 0) || (phase % 4 == 3);
            while (rand_sent < (phase + 1) * PHASE_ITEMS) begin
                send_random_sequence();
                if ($urandom_range(0, 7) == 0) wait_for_drain();
            end
            phase++;
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("[lexicographic_permutation_step] OK");
        end else begin
            $display("[lexicographic_permutation_step] ERROR");
        end
        $finish;
    end

endmodule
